/* design/ccde_pkg.sv */
// Shared constants, widths and helper functions of the delay estimator.
package ccde_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 48;
    localparam int LAG_W      = 9;
    localparam int POS_W      = 17;
    localparam int N_REG_W    = 7;
    localparam int S_REG_W    = 4;
    localparam int W_REG_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;

    localparam logic [N_REG_W-1:0] WINDOW_RESET = 7'd32;
    localparam logic [S_REG_W-1:0] SPREAD_RESET = 4'd3;
    localparam logic [W_REG_W-1:0] PERIOD_RESET = 16'd4096;

    localparam logic [POS_W-1:0] POS_LIMIT = '1;

    localparam int DEF_MAX_WINDOW    = 64;
    localparam int DEF_MAX_SPREAD    = 8;
    localparam int DEF_HISTORY_DEPTH = 1024;
    localparam int JOB_FIFO_DEPTH    = 2;

    // largest lag span L for the given limits
    function automatic int lag_max(input int max_window, input int max_spread);
        return max_window * (max_spread - 1) / 2;
    endfunction

    // upper bound on the sample age touched by one correlation
    function automatic int age_max(input int max_window, input int max_spread);
        return 2 * lag_max(max_window, max_spread) + max_window;
    endfunction

endpackage

/* design/ccde_if.sv */
// Valid/ready channels for sample words and lag words.
interface ccde_in_if
    import ccde_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] ref_sample;
    logic signed [SAMPLE_W-1:0] other_sample;

    modport source (output valid, output ref_sample, output other_sample, input ready);
    modport sink   (input valid, input ref_sample, input other_sample, output ready);
endinterface

interface ccde_out_if
    import ccde_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [LAG_W-1:0] lag_estimate;

    modport source (output valid, output lag_estimate, input ready);
    modport sink   (input valid, input lag_estimate, output ready);
endinterface

/* design/cross_correlation_delay_estimator.sv */
// Top level of the cross-correlation delay estimator.
//
// Usage:
//   in_ch  : one word per sample pair (reference, second antenna), Q1.15.
//   out_ch : one word per finished period, the lag of the first correlation
//            peak minus L, with L = N*(S-1)/2 (or -1 when L is zero).
//   cfg    : write-only registers window_length, spread, period_length,
//            written with cfg_we/cfg_index/cfg_data while the block is idle.
// Throughput: one sample word per cycle while no correlation and no phase
//   computation is running. The word that closes a period starts a
//   correlation of 2L lags by N taps; the input then holds off until the result
//   is loaded into the output register, the single multiply-accumulate pipe
//   reading both history RAMs one tap per cycle. L = 0 periods hold it off too.
// After a config write the emission phase is recomputed bit-serially; the
//   input holds off until it ends, one bit of the largest age per cycle.
// Reset: history reads as zero up to the stream start, counters clear, the
//   phase computation runs once, registers take 32, 3 and 4096.
// Stall: the result sits in an output register; a stalled receiver holds the
//   engine in its final state, the front holds until the new result has been
//   loaded into the output register.
module cross_correlation_delay_estimator
    import ccde_pkg::*;
#(
    parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
    parameter int MAX_SPREAD    = DEF_MAX_SPREAD,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ccde_in_if.sink               in_ch,
    ccde_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int L_MAX = lag_max(MAX_WINDOW, MAX_SPREAD);
    localparam int N_W   = $clog2(MAX_WINDOW + 1);
    localparam int L_W   = $clog2(L_MAX + 2);
    localparam int AGE_W = $clog2(age_max(MAX_WINDOW, MAX_SPREAD) + 1);
    localparam int HI_W  = $clog2(HISTORY_DEPTH);
    localparam int JOB_W = N_W + L_W + AGE_W + POS_W + HI_W;

    // history write side (front)
    logic                ram_we;
    logic [HI_W-1:0]     ram_waddr;
    logic [SAMPLE_W-1:0] ref_wdata, oth_wdata;
    // history read side (back)
    logic [HI_W-1:0]     ref_raddr, oth_raddr;
    logic [SAMPLE_W-1:0] ref_rdata, oth_rdata;
    // job queue
    logic                job_push, job_pop, job_full, job_empty;
    logic [JOB_W-1:0]    job_wdata, job_rdata;
    logic                back_done;

    ccde_front #(
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_SPREAD    (MAX_SPREAD),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .JOB_W         (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ref_wdata (ref_wdata),
        .oth_wdata (oth_wdata),
        .job_push  (job_push),
        .job_data  (job_wdata),
        .job_full  (job_full),
        .back_done (back_done)
    );

    ccde_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ref_wdata),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    ccde_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_oth_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (oth_wdata),
        .raddr (oth_raddr),
        .rdata (oth_rdata)
    );

    ccde_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_FIFO_DEPTH)
    ) u_job_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_wdata),
        .pop       (job_pop),
        .pop_data  (job_rdata),
        .full      (job_full),
        .empty     (job_empty)
    );

    ccde_back #(
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_SPREAD    (MAX_SPREAD),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .JOB_W         (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_data  (job_rdata),
        .job_pop   (job_pop),
        .ref_raddr (ref_raddr),
        .oth_raddr (oth_raddr),
        .ref_rdata (ref_rdata),
        .oth_rdata (oth_rdata),
        .back_done (back_done),
        .out_ch    (out_ch)
    );

endmodule

/* design/ccde_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ccde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/ccde_fifo.sv */
// Small job queue between the front and the correlation engine.
module ccde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/ccde_front.sv */
// Front end: config registers, sample capture, period tracking, job issue.
module ccde_front
    import ccde_pkg::*;
#(
    parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
    parameter int MAX_SPREAD    = DEF_MAX_SPREAD,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int JOB_W         = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ccde_in_if.sink                             in_ch,
    input  logic                                cfg_we,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [CFG_DATA_W-1:0]               cfg_data,
    output logic                                ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0]    ram_waddr,
    output logic [SAMPLE_W-1:0]                 ref_wdata,
    output logic [SAMPLE_W-1:0]                 oth_wdata,
    output logic                                job_push,
    output logic [JOB_W-1:0]                    job_data,
    input  logic                                job_full,
    input  logic                                back_done
);

    localparam int L_MAX = lag_max(MAX_WINDOW, MAX_SPREAD);
    localparam int N_W   = $clog2(MAX_WINDOW + 1);
    localparam int S_W   = $clog2(MAX_SPREAD + 1);
    localparam int L_W   = $clog2(L_MAX + 2);
    localparam int AGE_W = $clog2(age_max(MAX_WINDOW, MAX_SPREAD) + 1);
    localparam int HI_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(AGE_W + 1);

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [L_W-1:0]   l;
        logic [AGE_W-1:0] e;
        logic [POS_W-1:0] now;
        logic [HI_W-1:0]  wi;
    } job_t;

    logic [N_REG_W-1:0] window_reg;
    logic [S_REG_W-1:0] spread_reg;
    logic [W_REG_W-1:0] period_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [W_REG_W-1:0] phase_reg;
    logic [HI_W-1:0]    wi_reg;
    logic               hold_reg;
    logic [W_REG_W-1:0] rem_reg;
    logic [CNT_W-1:0]   bit_cnt_reg;

    logic [N_W-1:0]       n_eff;
    logic [S_W-1:0]       s_eff;
    logic [N_W+S_W-1:0]   l_prod;
    logic [L_W-1:0]       l_eff;
    logic [AGE_W-1:0]     e_eff;
    logic [W_REG_W-1:0]   w_eff;
    logic [POS_W-1:0]     due_pos;
    logic [AGE_W-1:0]     mod_in;
    logic [AGE_W-1:0]     mod_shift;
    logic [W_REG_W:0]     rem_trial;
    logic [W_REG_W-1:0]   target_phase;
    logic [W_REG_W:0]     phase_inc;
    logic                 mod_busy;
    logic                 accept;
    logic                 trigger;
    job_t                 job;

    always_comb
    begin
        if (window_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (32'(window_reg) > MAX_WINDOW)
        begin
            n_eff = N_W'(MAX_WINDOW);
        end
        else
        begin
            n_eff = N_W'(window_reg);
        end

        if (spread_reg == '0)
        begin
            s_eff = S_W'(1);
        end
        else if (32'(spread_reg) > MAX_SPREAD)
        begin
            s_eff = S_W'(MAX_SPREAD);
        end
        else
        begin
            s_eff = S_W'(spread_reg);
        end
    end

    assign l_prod = (N_W+S_W)'(n_eff) * (N_W+S_W)'(s_eff - 1'b1);
    assign l_eff  = L_W'(l_prod >> 1);
    assign e_eff  = (l_eff != '0) ? AGE_W'(l_eff) + AGE_W'(n_eff) - AGE_W'(2)
                                  : AGE_W'(n_eff) - AGE_W'(1);
    assign w_eff  = (period_reg == '0) ? W_REG_W'(1) : period_reg;
    assign due_pos = POS_W'(w_eff) - POS_W'(1) + POS_W'(e_eff);

    // emission phase is (W-1+E) mod W, found one bit per cycle after reset or a write
    assign mod_in    = e_eff - AGE_W'(1);
    assign mod_shift = mod_in >> (bit_cnt_reg - 1'b1);
    assign rem_trial = {rem_reg, mod_shift[0]};
    assign mod_busy  = (bit_cnt_reg != '0);
    assign target_phase = (e_eff == '0) ? w_eff - 1'b1 : rem_reg;

    assign in_ch.ready = !hold_reg && !mod_busy && !job_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign trigger     = (phase_reg == target_phase) && (pos_reg >= due_pos);
    assign phase_inc   = {1'b0, phase_reg} + 1'b1;

    assign ram_we    = accept;
    assign ram_waddr = wi_reg;
    assign ref_wdata = in_ch.ref_sample;
    assign oth_wdata = in_ch.other_sample;

    assign job.n   = n_eff;
    assign job.l   = l_eff;
    assign job.e   = e_eff;
    assign job.now = pos_reg;
    assign job.wi  = wi_reg;
    assign job_push = accept && trigger;
    assign job_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RESET;
            spread_reg  <= SPREAD_RESET;
            period_reg  <= PERIOD_RESET;
            pos_reg     <= '0;
            phase_reg   <= '0;
            wi_reg      <= '0;
            hold_reg    <= 1'b0;
            rem_reg     <= '0;
            bit_cnt_reg <= CNT_W'(AGE_W);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW: window_reg <= cfg_data[N_REG_W-1:0];
                    CFG_SPREAD: spread_reg <= cfg_data[S_REG_W-1:0];
                    CFG_PERIOD: period_reg <= cfg_data[W_REG_W-1:0];
                    default:    ;
                endcase
                rem_reg     <= '0;
                bit_cnt_reg <= CNT_W'(AGE_W);
            end
            else if (mod_busy)
            begin
                rem_reg     <= (rem_trial >= {1'b0, w_eff}) ? W_REG_W'(rem_trial - {1'b0, w_eff})
                                                            : W_REG_W'(rem_trial);
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end

            if (accept)
            begin
                if (pos_reg != POS_LIMIT)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                phase_reg <= (phase_inc >= {1'b0, w_eff}) ? '0 : W_REG_W'(phase_inc);
                wi_reg    <= (wi_reg == HI_W'(HISTORY_DEPTH - 1)) ? '0 : wi_reg + 1'b1;
            end

            if (job_push)
            begin
                hold_reg <= 1'b1;
            end
            else if (back_done)
            begin
                hold_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/ccde_back.sv */
// Back end: correlation engine, running max search and result register.
module ccde_back
    import ccde_pkg::*;
#(
    parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
    parameter int MAX_SPREAD    = DEF_MAX_SPREAD,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int JOB_W         = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             job_empty,
    input  logic [JOB_W-1:0]                 job_data,
    output logic                             job_pop,
    output logic [$clog2(HISTORY_DEPTH)-1:0] ref_raddr,
    output logic [$clog2(HISTORY_DEPTH)-1:0] oth_raddr,
    input  logic [SAMPLE_W-1:0]              ref_rdata,
    input  logic [SAMPLE_W-1:0]              oth_rdata,
    output logic                             back_done,
    ccde_out_if.source                       out_ch
);

    localparam int L_MAX = lag_max(MAX_WINDOW, MAX_SPREAD);
    localparam int N_W   = $clog2(MAX_WINDOW + 1);
    localparam int L_W   = $clog2(L_MAX + 2);
    localparam int M_W   = $clog2(2 * L_MAX + 2);
    localparam int AGE_W = $clog2(age_max(MAX_WINDOW, MAX_SPREAD) + 1);
    localparam int HI_W  = $clog2(HISTORY_DEPTH);

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [L_W-1:0]   l;
        logic [AGE_W-1:0] e;
        logic [POS_W-1:0] now;
        logic [HI_W-1:0]  wi;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    job_t   job_in;
    job_t   job_reg, job_next;
    logic [M_W-1:0] m_reg, m_next;
    logic [N_W-1:0] j_reg, j_next;
    logic           out_valid_reg, out_valid_next;
    logic [LAG_W-1:0] lag_reg, lag_next;

    logic                     s1_valid_reg, s1_zero_reg, s1_last_reg;
    logic [M_W-1:0]           s1_m_reg;
    logic                     s2_valid_reg, s2_last_reg;
    logic [M_W-1:0]           s2_m_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, peak_reg;
    logic [M_W-1:0]           top_reg;

    logic             issue;
    logic             last_j, last_m;
    logic [AGE_W:0]   ref_age, oth_age;
    logic             ref_zero, oth_zero;
    logic signed [ACC_W-1:0] sum;
    logic signed [31:0] lag_full;
    logic             load_out;

    function automatic logic [HI_W-1:0] ring_addr(input logic [HI_W-1:0] wi,
                                                  input logic [AGE_W:0] age);
        logic [HI_W:0] lo;
        lo = (HI_W+1)'(age);
        if ({1'b0, wi} >= lo)
        begin
            return HI_W'({1'b0, wi} - lo);
        end
        return HI_W'({1'b0, wi} + (HI_W+1)'(HISTORY_DEPTH) - lo);
    endfunction

    assign job_in = job_data;

    assign issue   = (state_reg == ST_RUN);
    assign last_j  = (j_reg == job_reg.n - 1'b1);
    assign last_m  = (m_reg == M_W'({job_reg.l, 1'b0}) - 1'b1);
    assign ref_age = (AGE_W+1)'(job_reg.e) - (AGE_W+1)'(j_reg);
    assign oth_age = (AGE_W+1)'(job_reg.e) + (AGE_W+1)'(job_reg.l)
                   - (AGE_W+1)'(m_reg) - (AGE_W+1)'(j_reg);
    // samples before stream start or older than the buffer read as zero
    assign ref_zero = (POS_W'(ref_age) > job_reg.now) || (32'(ref_age) >= HISTORY_DEPTH);
    assign oth_zero = (POS_W'(oth_age) > job_reg.now) || (32'(oth_age) >= HISTORY_DEPTH);
    assign ref_raddr = ring_addr(job_reg.wi, ref_age);
    assign oth_raddr = ring_addr(job_reg.wi, oth_age);

    assign sum      = acc_reg + ACC_W'(prod_reg);
    assign lag_full = 32'(top_reg) - 32'(job_reg.l);
    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    assign back_done = load_out;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.lag_estimate = lag_reg;

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        m_next         = m_reg;
        j_next         = j_reg;
        job_pop        = 1'b0;
        lag_next       = lag_reg;
        out_valid_next = out_valid_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop  = 1'b1;
                    job_next = job_in;
                    m_next   = '0;
                    j_next   = '0;
                    state_next = (job_in.l == '0) ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_j)
                begin
                    j_next = '0;
                    if (last_m)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        m_next = m_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    lag_next   = (job_reg.l == '0) ? '1 : lag_full[LAG_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        m_reg   <= m_next;
        j_reg   <= j_next;
        lag_reg <= lag_next;

        s1_zero_reg <= ref_zero || oth_zero;
        s1_last_reg <= last_j;
        s1_m_reg    <= m_reg;

        s2_last_reg <= s1_last_reg;
        s2_m_reg    <= s1_m_reg;
        // keep the product in a purely signed context
        if (s1_zero_reg)
        begin
            prod_reg <= '0;
        end
        else
        begin
            prod_reg <= $signed(ref_rdata) * $signed(oth_rdata);
        end

        if (state_reg == ST_IDLE)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                acc_reg <= '0;
                if (s2_m_reg == '0 || sum > peak_reg)
                begin
                    peak_reg <= sum;
                    top_reg  <= s2_m_reg;
                end
            end
            else
            begin
                acc_reg <= sum;
            end
        end
    end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the cross-correlation delay estimator.
`timescale 1ns / 1ps

module tb_top
    import ccde_pkg::*;
;

    localparam int HIST_DEPTH  = DEF_HISTORY_DEPTH;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccde_in_if  in_ch ();
    ccde_out_if out_ch ();

    cross_correlation_delay_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Shadow copy of the estimator: histories, counters and registers.
    // ------------------------------------------------------------------
    logic [15:0] ref_hist [HIST_DEPTH];
    logic [15:0] oth_hist [HIST_DEPTH];
    int unsigned samples_seen;     // saturates at the position limit
    int unsigned phase;            // sample index modulo W
    int unsigned wr_ptr;
    logic [N_REG_W-1:0] win_reg;
    logic [S_REG_W-1:0] spread_reg;
    logic [W_REG_W-1:0] period_reg;

    logic signed [LAG_W-1:0] lag_q [$];   // lags still owed by the block

    int mismatches;
    int lags_checked;
    int words_sent;
    int neg_one_lags;
    longint cycles;

    // stimulus knobs
    bit tx_idle;                  // sender inserts random gaps
    bit rx_idle;                  // receiver inserts random stalls
    int rx_hold;                  // one-off long stall request, in cycles

    // recent samples for building delayed copies
    logic [15:0] recent_ref [256];
    logic [15:0] recent_oth [256];
    int unsigned recent_ptr;

    function automatic int hist_at(bit from_ref, int unsigned age, int unsigned now);
        int unsigned idx;
        if (age > now || age >= HIST_DEPTH)
            return 0;
        idx = (wr_ptr + HIST_DEPTH - age) % HIST_DEPTH;
        return from_ref ? int'($signed(ref_hist[idx])) : int'($signed(oth_hist[idx]));
    endfunction

    // One accepted sample pair: store it and, if it closes a period, queue the lag.
    function automatic void predict_lag(logic [15:0] r, logic [15:0] o);
        int unsigned now, n, s, w, l, e, d, top;
        longint acc, peak;
        now = samples_seen;
        n = win_reg;
        s = spread_reg;
        w = period_reg;
        if (n < 1) n = 1;
        if (n > DEF_MAX_WINDOW) n = DEF_MAX_WINDOW;
        if (s < 1) s = 1;
        if (s > DEF_MAX_SPREAD) s = DEF_MAX_SPREAD;
        if (w < 1) w = 1;
        ref_hist[wr_ptr] = r;
        oth_hist[wr_ptr] = o;
        l = n * (s - 1) / 2;
        e = (l >= 1) ? (l + n - 2) : (n - 1);
        d = w - 1 + e;
        if (phase == d % w && now >= d)
        begin
            if (l == 0)
            begin
                lag_q.insert(lag_q.size(), -9'sd1);
            end
            else
            begin
                top = 0;
                peak = 0;
                for (int unsigned m = 0; m < 2 * l; m++)
                begin
                    acc = 0;
                    for (int unsigned j = 0; j < n; j++)
                        acc += longint'(hist_at(1'b1, e - j, now) *
                                        hist_at(1'b0, e + l - m - j, now));
                    // first maximum wins ties
                    if (m == 0 || acc > peak)
                    begin
                        peak = acc;
                        top = m;
                    end
                end
                lag_q.insert(lag_q.size(), LAG_W'(int'(top) - int'(l)));
            end
        end
        if (samples_seen < POS_LIMIT)
            samples_seen++;
        phase = (phase + 1 >= w) ? 0 : phase + 1;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------
    task automatic send_pair(input logic [15:0] r, input logic [15:0] o);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.ref_sample   <= r;
        in_ch.other_sample <= o;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        predict_lag(r, o);
        recent_ref[recent_ptr] = r;
        recent_oth[recent_ptr] = o;
        recent_ptr = (recent_ptr + 1) % 256;
        words_sent++;
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sender pause: every owed lag back, then room for the engine to settle.
    task automatic drain();
        stop_sending();
        while (lag_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW: win_reg    = val[N_REG_W-1:0];
            CFG_SPREAD: spread_reg = val[S_REG_W-1:0];
            CFG_PERIOD: period_reg = val[W_REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int n, input int s, input int w);
        drain();
        write_reg(CFG_WINDOW, 16'(n));
        write_reg(CFG_SPREAD, 16'(s));
        write_reg(CFG_PERIOD, 16'(w));
        @(posedge clk);
    endtask

    // Random words: mostly a delayed copy of one stream in the other, so that
    // the correlation has a true peak; the rest is plain noise.
    task automatic random_words(input int count, input int max_dly);
        int dly;
        logic [15:0] r, o;
        int unsigned p;
        dly = $urandom_range(0, 2 * max_dly) - max_dly;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                dly = $urandom_range(0, 2 * max_dly) - max_dly;
            r = $urandom;
            o = $urandom;
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 1))
                    r = 16'($signed(r) >>> $urandom_range(0, 8));
                if (dly >= 0)
                begin
                    p = (recent_ptr + 256 - dly) % 256;
                    o = (dly == 0) ? r : recent_ref[p];
                end
                else
                begin
                    p = (recent_ptr + 256 + dly) % 256;
                    r = recent_oth[p];
                end
                if ($urandom_range(0, 3) == 0)
                    o = o + 16'($urandom_range(0, 63)) - 16'd32;
            end
            if ((i % 300) < 40)
                tx_idle = 1'b0;      // burst with no sender gaps
            else
                tx_idle = 1'b1;
            send_pair(r, o);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full-scale values, zeros and a lone pulse, N=4 S=3 W=8 (L=4).
    task automatic test_directed();
        logic [15:0] pat [24];
        configure(4, 3, 8);
        for (int i = 0; i < 24; i++)
            pat[i] = 16'h0000;
        pat[0] = 16'h8000; pat[1] = 16'h7FFF; pat[2] = 16'h8000; pat[3] = 16'h7FFF;
        pat[9] = 16'h7FFF; pat[10] = 16'h0001; pat[11] = 16'hFFFF;
        pat[17] = 16'h8000; pat[18] = 16'h8000; pat[19] = 16'h8000; pat[20] = 16'h7FFF;
        for (int i = 0; i < 24; i++)
            send_pair(pat[i], (i >= 2) ? pat[i-2] : 16'h8000);
    endtask

    // Spread of 1 gives no lags; every window reports -1.
    task automatic test_no_lags();
        configure(1, 1, 1);
        random_words(120, 0);
        configure(127, 0, 3);        // N clamps to the max, S to 1
        random_words(120, 0);
    endtask

    // Zero registers: N and W act as 1, S=15 clamps to the max spread.
    task automatic test_clamped_regs();
        configure(0, 15, 0);
        random_words(200, 3);
    endtask

    task automatic test_small_windows();
        configure(2, 3, 5);
        random_words(250, 2);
        configure(3, 2, 4);
        random_words(200, 1);
        configure(5, 5, 16);
        random_words(250, 10);
        configure(8, 4, 20);
        random_words(300, 12);
    endtask

    // Largest window and spread (L=224), and the longest period.
    task automatic test_extremes();
        configure(64, 8, 600);
        random_words(700, 100);
        configure(16, 2, 65535);
        random_words(100, 8);
    endtask

    // Receiver holds off while the sender keeps offering words.
    task automatic test_backpressure();
        configure(2, 2, 1);
        rx_hold = 2000;
        random_words(150, 1);
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            k = rx_idle ? $urandom_range(0, 19) : 0;
            if (k > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (k) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready) && rx_hold == 0);
            if ($urandom_range(0, 9) == 0)
                rx_idle = !rx_idle;
        end
    end

    always @(posedge clk)
    begin
        logic signed [LAG_W-1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (lag_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected lag word %0d", out_ch.lag_estimate);
            end
            else
            begin
                want = lag_q.pop_front();
                lags_checked++;
                if (want == -9'sd1)
                    neg_one_lags++;
                if (out_ch.lag_estimate !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: lag_estimate expected %0d got %0d",
                                 want, out_ch.lag_estimate);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.ref_sample   <= '0;
        in_ch.other_sample <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_WINDOW;
        cfg_data  <= '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            ref_hist[i] = '0;
            oth_hist[i] = '0;
        end
        for (int i = 0; i < 256; i++)
        begin
            recent_ref[i] = '0;
            recent_oth[i] = '0;
        end
        samples_seen = 0;
        phase = 0;
        wr_ptr = 0;
        recent_ptr = 0;
        win_reg = WINDOW_RESET;
        spread_reg = SPREAD_RESET;
        period_reg = PERIOD_RESET;
        mismatches = 0;
        lags_checked = 0;
        words_sent = 0;
        neg_one_lags = 0;
        cycles = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rx_hold = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_no_lags();
        test_clamped_regs();
        test_small_windows();
        test_backpressure();
        test_extremes();

        drain();
        repeat (100) @(posedge clk);

        $display("Sent %0d sample words, checked %0d lag words (%0d with no lags).",
                 words_sent, lags_checked, neg_one_lags);
        $display("Covered clamped registers, full-scale samples, L up to 224 and a long stall.");
        if (mismatches == 0 && lag_q.size() == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d bad words, %0d lag words never arrived", mismatches, lag_q.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
design/ccde_pkg.sv
design/ccde_if.sv
design/ccde_ram.sv
design/ccde_fifo.sv
design/ccde_front.sv
design/ccde_back.sv
design/cross_correlation_delay_estimator.sv
verif/tb_top.sv
